@@ hdl/lzwsc_pkg.sv @@
// Shared constants, codes and controller/datapath types of the LZW stream compressor.
package lzwsc_pkg;

	localparam int MAX_CODE_BITS   = 12;
	localparam int START_CODE_BITS = 9;
	localparam int FIRST_FREE_CODE = 256;
	localparam int HASH_BITS       = 12;
	localparam int DICT_SIZE       = 1 << MAX_CODE_BITS;
	localparam int CODE_W          = MAX_CODE_BITS + 1;
	localparam int LEN_W           = 20;

	localparam logic [CODE_W-1:0] NO_CODE = CODE_W'(DICT_SIZE);

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_HEAD_CHK,
		ST_CMP,
		ST_EMIT,
		ST_UPDATE,
		ST_CHECK,
		ST_FLUSH,
		ST_DELIVER
	} lzwsc_state_t;

	typedef struct packed {
		logic [MAX_CODE_BITS-1:0] prefix;
		logic [7:0]               suffix;
		logic [CODE_W-1:0]        next;
	} lzwsc_entry_t;

	typedef struct packed {
		logic latch;
		logic first;
		logic head_rd;
		logic dict_rd_head;
		logic dict_rd_next;
		logic hit;
		logic pack;
		logic emit;
		logic update;
		logic check;
		logic flush;
		logic pop;
		logic clr_step;
	} lzwsc_cmd_t;

	typedef struct packed {
		logic is_end;
		logic match_valid;
		logic head_empty;
		logic cmp_hit;
		logic next_empty;
		logic acc_ge8;
		logic q_empty;
		logic last;
		logic clr_pend;
		logic clr_done;
	} lzwsc_stat_t;

endpackage

@@ hdl/lzwsc_if.sv @@
// Valid/ready channel interfaces for input items and result words.
interface lzwsc_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface lzwsc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        stream_end;
	logic [19:0] total_length;
	logic        failed;
	logic        overflow;

	modport source (output valid, out_byte, byte_valid, stream_end, total_length, failed,
		overflow, input ready);
	modport sink (input valid, out_byte, byte_valid, stream_end, total_length, failed,
		overflow, output ready);
endinterface

@@ hdl/lzwsc_ctrl.sv @@
// Controller state machine: sequences probe, chain walk, packing, update and delivery.
module lzwsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_ready,
	input  lzwsc_pkg::lzwsc_stat_t stat,
	output lzwsc_pkg::lzwsc_cmd_t  cmd,
	output logic                 in_ready,
	output logic                 out_valid
);
	import lzwsc_pkg::*;

	lzwsc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_START;
				end
			end
			ST_START: begin
				if (stat.is_end) begin
					cmd.pack = stat.match_valid;
					state_d  = ST_EMIT;
				end else if (!stat.match_valid) begin
					cmd.first = 1'b1;
					state_d   = ST_CHECK;
				end else begin
					cmd.head_rd = 1'b1;
					state_d     = ST_HEAD_CHK;
				end
			end
			ST_HEAD_CHK: begin
				if (stat.head_empty) begin
					cmd.pack = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.dict_rd_head = 1'b1;
					state_d          = ST_CMP;
				end
			end
			ST_CMP: begin
				if (stat.cmp_hit) begin
					cmd.hit = 1'b1;
					state_d = ST_CHECK;
				end else if (stat.next_empty) begin
					cmd.pack = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.dict_rd_next = 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.acc_ge8) begin
					cmd.emit = 1'b1;
				end else if (stat.is_end) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (!stat.q_empty) state_d = ST_DELIVER;
				else if (stat.clr_pend) state_d = ST_CLEAR;
				else state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_DELIVER;
			end
			ST_DELIVER: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.pop = 1'b1;
					if (stat.last) state_d = stat.clr_pend ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ hdl/lzwsc_dp.sv @@
// Datapath: dictionary and hash head memories, bit packer, counters and result queue.
module lzwsc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzwsc_pkg::lzwsc_cmd_t  cmd,
	output lzwsc_pkg::lzwsc_stat_t stat,
	input  logic                 cfg_wr_en,
	input  logic [19:0]          cfg_wr_data,
	input  logic                 in_cmd,
	input  logic [7:0]           in_data_byte,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 stream_end,
	output logic [19:0]          total_length,
	output logic                 failed,
	output logic                 overflow
);
	import lzwsc_pkg::*;

	lzwsc_entry_t dict_mem [DICT_SIZE];
	logic [CODE_W-1:0] head_mem [1 << HASH_BITS];

	logic                     cmd_q;
	logic [7:0]               k_q;
	logic [MAX_CODE_BITS-1:0] match_q;
	logic [MAX_CODE_BITS-1:0] j_q;
	logic                     mvalid_q;
	logic [CODE_W-1:0]        nfc_q;
	logic [3:0]               width_q;
	logic [19:0]              acc_q;
	logic [4:0]               bc_q;
	logic [LEN_W-1:0]         bw_q;
	logic [LEN_W-1:0]         max_q;
	logic                     ovf_q;
	logic                     fail_q;
	logic [CODE_W-1:0]        head_rd_q;
	lzwsc_entry_t             dict_rd_q;
	logic [HASH_BITS-1:0]     clr_q;
	logic                     clr_pend_q;
	logic [7:0]               q_byte_q [3];
	logic [1:0]               q_cnt_q;
	logic [1:0]               q_rd_q;

	logic [HASH_BITS-1:0]     hash;
	logic                     at_limit;
	logic                     restart;
	logic                     grow;
	logic [5:0]               pend_bits;
	logic [LEN_W:0]           end_need;
	logic [MAX_CODE_BITS-1:0] dict_ra;
	logic                     last;

	assign hash     = HASH_BITS'(match_q ^ MAX_CODE_BITS'(k_q));
	assign at_limit = (bw_q >= max_q);
	assign restart  = (nfc_q == (CODE_W'(1) << width_q)) && (width_q == 4'(MAX_CODE_BITS));
	assign grow     = (nfc_q == (CODE_W'(1) << width_q)) && !restart;
	assign pend_bits = 6'(width_q) + 6'(bc_q) + 6'd7;
	assign end_need = {1'b0, bw_q} + (LEN_W+1)'(pend_bits >> 3);
	assign dict_ra  = cmd.dict_rd_head ? head_rd_q[MAX_CODE_BITS-1:0]
		: dict_rd_q.next[MAX_CODE_BITS-1:0];
	assign last     = (q_cnt_q == 2'd0) || (q_rd_q == q_cnt_q - 2'd1);

	always_comb begin
		stat             = '0;
		stat.is_end      = (cmd_q == CMD_END);
		stat.match_valid = mvalid_q;
		stat.head_empty  = head_rd_q[CODE_W-1];
		stat.cmp_hit     = (dict_rd_q.suffix == k_q) && (dict_rd_q.prefix == match_q);
		stat.next_empty  = dict_rd_q.next[CODE_W-1];
		stat.acc_ge8     = (bc_q >= 5'd8);
		stat.q_empty     = (q_cnt_q == 2'd0);
		stat.last        = last;
		stat.clr_pend    = clr_pend_q;
		stat.clr_done    = &clr_q;
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.clr_step) head_mem[clr_q] <= NO_CODE;
		else if (cmd.update && !restart) head_mem[hash] <= nfc_q;
		if (cmd.head_rd) head_rd_q <= head_mem[hash];
	end

	always_ff @(posedge clk) begin
		if (cmd.update && !restart)
			dict_mem[nfc_q[MAX_CODE_BITS-1:0]] <= '{prefix: match_q, suffix: k_q, next: head_rd_q};
		if (cmd.dict_rd_head || cmd.dict_rd_next) begin
			dict_rd_q <= dict_mem[dict_ra];
			j_q       <= dict_ra;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= in_cmd;
			k_q   <= in_data_byte;
		end
		if (cmd.first || cmd.update) match_q <= k_q;
		else if (cmd.hit) match_q <= j_q;
		if (cmd.emit && !at_limit) q_byte_q[q_cnt_q] <= acc_q[7:0];
		else if (cmd.flush && bc_q != 5'd0 && !at_limit)
			q_byte_q[q_cnt_q] <= acc_q[7:0] & ((8'd1 << bc_q[2:0]) - 8'd1);
		if (cmd.flush)
			fail_q <= (bc_q != 5'd0) ? at_limit : (bw_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q   <= 1'b0;
			nfc_q      <= CODE_W'(FIRST_FREE_CODE);
			width_q    <= 4'(START_CODE_BITS);
			acc_q      <= '0;
			bc_q       <= '0;
			bw_q       <= '0;
			max_q      <= '1;
			ovf_q      <= 1'b0;
			clr_q      <= '0;
			clr_pend_q <= 1'b1;
			q_cnt_q    <= '0;
			q_rd_q     <= '0;
		end else begin
			if (cfg_wr_en) max_q <= cfg_wr_data;
			if (cmd.latch) begin
				q_cnt_q <= '0;
				q_rd_q  <= '0;
			end
			if (cmd.first) mvalid_q <= 1'b1;
			if (cmd.clr_step) begin
				clr_q <= clr_q + HASH_BITS'(1);
				if (&clr_q) clr_pend_q <= 1'b0;
			end
			if (cmd.pack) begin
				acc_q <= acc_q | (20'(match_q) << bc_q);
				bc_q  <= bc_q + 5'(width_q);
			end
			if (cmd.emit) begin
				if (at_limit) begin
					ovf_q <= 1'b1;
				end else begin
					q_cnt_q <= q_cnt_q + 2'd1;
					bw_q    <= bw_q + LEN_W'(1);
				end
				acc_q <= acc_q >> 8;
				bc_q  <= bc_q - 5'd8;
			end
			if (cmd.update) begin
				if (restart) begin
					nfc_q      <= CODE_W'(FIRST_FREE_CODE);
					width_q    <= 4'(START_CODE_BITS);
					clr_pend_q <= 1'b1;
				end else begin
					if (grow) width_q <= width_q + 4'd1;
					nfc_q <= nfc_q + CODE_W'(1);
				end
			end
			if (cmd.check && end_need >= {1'b0, max_q}) ovf_q <= 1'b1;
			if (cmd.flush) begin
				if (bc_q != 5'd0) begin
					if (at_limit) begin
						ovf_q <= 1'b1;
					end else begin
						q_cnt_q <= q_cnt_q + 2'd1;
						bw_q    <= bw_q + LEN_W'(1);
					end
				end
				acc_q <= '0;
				bc_q  <= '0;
			end
			if (cmd.pop) q_rd_q <= q_rd_q + 2'd1;
		end
	end

	assign byte_valid   = (q_cnt_q != 2'd0);
	assign out_byte     = byte_valid ? q_byte_q[q_rd_q] : 8'd0;
	assign stream_end   = (cmd_q == CMD_END) && last;
	assign total_length = stream_end ? bw_q : '0;
	assign failed       = stream_end && fail_q;
	assign overflow     = ovf_q;

`ifndef SYNTHESIS
	a_drop_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && at_limit) |=> $stable(bw_q))
		else $error("dropped word changed the byte count");
	a_pack_adds_width: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pack |=> (bc_q == $past(bc_q) + 5'($past(width_q))))
		else $error("pack did not add the code width");
	a_code_fits_width: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q <= (CODE_W'(1) << width_q))
		else $error("free code beyond current width");
`endif
endmodule

@@ hdl/lzw_stream_compressor_unit.sv @@
// Top level of the LZW stream compressor: controller, datapath and channel hookup.
// One byte in, LSB-first packed LZW codes out (9 to 12 bits, dictionary of 4096 codes,
// restarted silently when full). The first byte of a stream only starts the match; a byte
// that extends the match walks the hash chain in the dictionary memory entry by entry; a miss
// ends the probe or chain walk, then packs the code, emits one or two full bytes and updates
// the dictionary, and every step then delivers its result words. After reset, and after each
// dictionary restart, the 4096 hash heads are swept one per cycle before the next item is
// taken. An end command flushes the code and partial byte and closes with the total length;
// the block keeps its dictionary, so a new stream needs a reset.
module lzw_stream_compressor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [19:0] cfg_wr_data,
	lzwsc_in_if.sink    in_ch,
	lzwsc_out_if.source out_ch
);
	import lzwsc_pkg::*;

	lzwsc_cmd_t  cmd;
	lzwsc_stat_t stat;

	lzwsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid)
	);

	lzwsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_cmd       (in_ch.cmd),
		.in_data_byte (in_ch.data_byte),
		.out_byte     (out_ch.out_byte),
		.byte_valid   (out_ch.byte_valid),
		.stream_end   (out_ch.stream_end),
		.total_length (out_ch.total_length),
		.failed       (out_ch.failed),
		.overflow     (out_ch.overflow)
	);
endmodule
